>>> rtl/core/srmm_pkg.sv
// ----------------------------------------------------------------------------
// srmm_pkg
// Shared constants, codes and controller/datapath types of the sparse
// row-wise matrix multiplier.
// ----------------------------------------------------------------------------
package srmm_pkg;

  localparam int MAX_DIM  = 64;
  localparam int MAX_NNZ  = 1024;

  localparam int DIM_W    = $clog2(MAX_DIM + 1);   // holds 0..MAX_DIM
  localparam int IDX_W    = 6;                     // row / column field width
  localparam int CNT_W    = $clog2(MAX_NNZ + 1);   // holds 0..MAX_NNZ
  localparam int NNZ_AW   = $clog2(MAX_NNZ);
  localparam int RS_DEPTH = MAX_DIM + 1;
  localparam int RS_AW    = $clog2(RS_DEPTH);
  localparam int ACC_AW   = $clog2(MAX_DIM);
  localparam int VAL_W    = 32;
  localparam int ACC_W    = 64;
  localparam int ROWC_W   = 16;
  localparam int THR_W    = 31;
  localparam int BENT_W   = IDX_W + VAL_W;

  // Register map
  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_INNER_DIM = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_B_COLS    = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_DROP_THR  = 2'd2;

  localparam logic [6:0]       INNER_DIM_RST = 7'd64;
  localparam logic [6:0]       B_COLS_RST    = 7'd64;
  localparam logic [THR_W-1:0] DROP_THR_RST  = '0;

  typedef enum logic [1:0] {
    OP_LOAD_B  = 2'd0,
    OP_A_ELEM  = 2'd1,
    OP_CLOSE   = 2'd2,
    OP_CLEAR_B = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LD_CHK,
    S_LD_FILL,
    S_LD_WR,
    S_A_RD0,
    S_A_RD1,
    S_A_RD2,
    S_A_BRD,
    S_A_MUL,
    S_A_ADD,
    S_C_RD,
    S_C_EVAL,
    S_C_FIN
  } state_t;

  typedef struct packed {
    logic [6:0]       inner_dim;
    logic [6:0]       b_cols;
    logic [THR_W-1:0] drop_threshold;
  } cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic latch;
    logic clear_b;
    logic fill_init;
    logic fill_wr;
    logic wr_b;
    logic rs_rd0;
    logic rs_rd1;
    logic rs_rd2;
    logic b_rd;
    logic mul;
    logic acc_add;
    logic p_inc;
    logic c_rd;
    logic j_inc;
    logic c_take;
    logic c_push;
    logic c_fin;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic             ld_ok;
    logic             ld_open;
    logic             fill_last;
    logic             a_ok;
    logic             p_done;
    logic             j_skip;
    logic             c_done;
    logic             touched;
    logic             kept;
    logic             pend_v;
    logic             out_free;
    logic [DIM_W-1:0] filled;
    logic [CNT_W-1:0] count;
  } stat_t;

endpackage

>>> rtl/core/srmm_in_if.sv
// ----------------------------------------------------------------------------
// srmm_in_if
// Request channel into the multiplier: operation code and element.
// ----------------------------------------------------------------------------
interface srmm_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        op;
  logic [5:0]        row;
  logic [5:0]        col;
  logic signed [31:0] value;

  modport source (output valid, op, row, col, value, input ready);
  modport sink   (input valid, op, row, col, value, output ready);
endinterface

>>> rtl/core/srmm_out_if.sv
// ----------------------------------------------------------------------------
// srmm_out_if
// Result channel out of the multiplier: product entries of each closed row.
// ----------------------------------------------------------------------------
interface srmm_out_if;
  logic               valid;
  logic               ready;
  logic [15:0]        out_row;
  logic [5:0]         out_col;
  logic signed [31:0] out_value;
  logic               empty_row;
  logic               last;

  modport source (output valid, out_row, out_col, out_value, empty_row, last, input ready);
  modport sink   (input valid, out_row, out_col, out_value, empty_row, last, output ready);
endinterface

>>> rtl/core/srmm_ram.sv
// ----------------------------------------------------------------------------
// srmm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module srmm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic                                        re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, hold data when idle
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/srmm_datapath.sv
// ----------------------------------------------------------------------------
// srmm_datapath
// B store, row-start table, accumulators, touched map and result registers.
// ----------------------------------------------------------------------------
module srmm_datapath (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [5:0]                in_row,
  input  logic [5:0]                in_col,
  input  logic signed [31:0]        in_value,
  input  srmm_pkg::cfg_t            cfg,
  input  srmm_pkg::cmd_t            cmd,
  output srmm_pkg::stat_t           stat,
  srmm_out_if.source                out
);

  localparam int DIM_W  = srmm_pkg::DIM_W;
  localparam int IDX_W  = srmm_pkg::IDX_W;
  localparam int CNT_W  = srmm_pkg::CNT_W;
  localparam int VAL_W  = srmm_pkg::VAL_W;
  localparam int ACC_W  = srmm_pkg::ACC_W;

  // Latched request
  logic [IDX_W-1:0]        row_r;
  logic [IDX_W-1:0]        col_r;
  logic signed [VAL_W-1:0] val_r;

  // B store bookkeeping
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [DIM_W-1:0] filled_r, filled_nxt;
  logic [CNT_W-1:0] cur_start_r, cur_start_nxt;
  logic [IDX_W-1:0] last_col_r, last_col_nxt;
  logic [DIM_W-1:0] q_r, q_nxt;

  // Walk and scan counters
  logic [CNT_W-1:0] p_r, p_nxt;
  logic [CNT_W-1:0] end_r, end_nxt;
  logic [DIM_W-1:0] j_r, j_nxt;
  logic [srmm_pkg::MAX_DIM-1:0] touched_r, touched_nxt;
  logic signed [ACC_W-1:0] prod_r;

  // Pending and output entries
  logic                    pend_v_r, pend_v_nxt;
  logic [IDX_W-1:0]        pend_col_r;
  logic [VAL_W-1:0]        pend_val_r;
  logic                    out_v_r, out_v_nxt;
  logic [srmm_pkg::ROWC_W-1:0] rowcnt_r, rowcnt_nxt;
  logic [srmm_pkg::ROWC_W-1:0] out_row_r;
  logic [IDX_W-1:0]        out_col_r;
  logic [VAL_W-1:0]        out_val_r;
  logic                    out_empty_r;
  logic                    out_last_r;

  // Effective dimensions
  logic [DIM_W-1:0] eff_inner, eff_cols;
  always_comb begin
    eff_inner = (cfg.inner_dim > 7'(srmm_pkg::MAX_DIM)) ?
                DIM_W'(srmm_pkg::MAX_DIM) : DIM_W'(cfg.inner_dim);
    eff_cols  = (cfg.b_cols > 7'(srmm_pkg::MAX_DIM)) ?
                DIM_W'(srmm_pkg::MAX_DIM) : DIM_W'(cfg.b_cols);
  end

  // Memories
  logic                              b_we, b_re;
  logic [srmm_pkg::BENT_W-1:0]       b_rdata;
  logic [IDX_W-1:0]                  b_col;
  logic signed [VAL_W-1:0]           b_val;
  logic                              rs_we, rs_re;
  logic [srmm_pkg::RS_AW-1:0]        rs_raddr;
  logic [CNT_W-1:0]                  rs_rdata;
  logic                              acc_we, acc_re;
  logic [srmm_pkg::ACC_AW-1:0]       acc_raddr;
  logic signed [ACC_W-1:0]           acc_rdata, acc_wdata;

  assign b_col = b_rdata[srmm_pkg::BENT_W-1:VAL_W];
  assign b_val = $signed(b_rdata[VAL_W-1:0]);

  assign b_we  = cmd.wr_b;
  assign b_re  = cmd.b_rd;
  srmm_ram #(.WIDTH(srmm_pkg::BENT_W), .DEPTH(srmm_pkg::MAX_NNZ)) u_b_store (
    .clk   (clk),
    .we    (b_we),
    .waddr (count_r[srmm_pkg::NNZ_AW-1:0]),
    .wdata ({col_r, val_r}),
    .re    (b_re),
    .raddr (p_r[srmm_pkg::NNZ_AW-1:0]),
    .rdata (b_rdata)
  );

  assign rs_we    = cmd.fill_wr;
  assign rs_re    = cmd.rs_rd0 | cmd.rs_rd1;
  assign rs_raddr = cmd.rs_rd1 ? srmm_pkg::RS_AW'({1'b0, col_r} + 7'd1)
                               : srmm_pkg::RS_AW'(col_r);
  srmm_ram #(.WIDTH(CNT_W), .DEPTH(srmm_pkg::RS_DEPTH)) u_row_start (
    .clk   (clk),
    .we    (rs_we),
    .waddr (srmm_pkg::RS_AW'(q_r)),
    .wdata (count_r),
    .re    (rs_re),
    .raddr (rs_raddr),
    .rdata (rs_rdata)
  );

  assign acc_we    = cmd.acc_add;
  assign acc_re    = cmd.mul | cmd.c_rd;
  assign acc_raddr = cmd.mul ? srmm_pkg::ACC_AW'(b_col) : srmm_pkg::ACC_AW'(j_r);
  srmm_ram #(.WIDTH(ACC_W), .DEPTH(srmm_pkg::MAX_DIM)) u_acc (
    .clk   (clk),
    .we    (acc_we),
    .waddr (srmm_pkg::ACC_AW'(b_col)),
    .wdata (acc_wdata),
    .re    (acc_re),
    .raddr (acc_raddr),
    .rdata (acc_rdata)
  );

  // Saturating accumulate; first touch in a row starts from zero
  logic signed [ACC_W-1:0] acc_base;
  logic [ACC_W:0]          acc_sum;
  always_comb begin
    acc_base = touched_r[srmm_pkg::ACC_AW'(b_col)] ? acc_rdata : '0;
    acc_sum  = {acc_base[ACC_W-1], acc_base} + {prod_r[ACC_W-1], prod_r};
    if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
      acc_wdata = acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      acc_wdata = $signed(acc_sum[ACC_W-1:0]);
    end
  end

  // Q32.32 to Q16.16: truncate toward zero, saturate
  logic              a_neg;
  logic [ACC_W-1:0]  a_mag;
  logic [47:0]       a_q;
  logic [VAL_W:0]    cand_mag;
  logic [VAL_W-1:0]  cand_val;
  always_comb begin
    a_neg = acc_rdata[ACC_W-1];
    a_mag = a_neg ? (ACC_W'(0) - acc_rdata) : acc_rdata;
    a_q   = a_mag[ACC_W-1:16];
    if (!a_neg && a_q > 48'h0000_7FFF_FFFF) begin
      cand_mag = 33'h0_7FFF_FFFF;
    end else if (a_neg && a_q > 48'h0000_8000_0000) begin
      cand_mag = 33'h0_8000_0000;
    end else begin
      cand_mag = a_q[VAL_W:0];
    end
    cand_val = a_neg ? (VAL_W'(0) - cand_mag[VAL_W-1:0]) : cand_mag[VAL_W-1:0];
  end

  // Status toward the controller
  logic [DIM_W-1:0] row_p1;
  logic [DIM_W-1:0] k_p1;
  assign row_p1 = {1'b0, row_r} + 7'd1;
  assign k_p1   = {1'b0, col_r} + 7'd1;

  always_comb begin
    stat.ld_ok = ({1'b0, row_r} < eff_inner) && ({1'b0, col_r} < eff_cols) &&
                 (count_r < CNT_W'(srmm_pkg::MAX_NNZ)) && !(row_p1 < filled_r) &&
                 !((row_p1 == filled_r) && (count_r > cur_start_r) &&
                   (col_r <= last_col_r));
    stat.ld_open   = row_p1 > filled_r;
    stat.fill_last = q_r == {1'b0, row_r};
    stat.a_ok      = {1'b0, col_r} < eff_inner;
    stat.p_done    = p_r >= end_r;
    stat.j_skip    = {1'b0, b_col} >= eff_cols;
    stat.c_done    = j_r >= eff_cols;
    stat.touched   = touched_r[srmm_pkg::ACC_AW'(j_r)];
    stat.kept      = cand_mag > {2'b00, cfg.drop_threshold};
    stat.pend_v    = pend_v_r;
    stat.out_free  = !out_v_r || out.ready;
    stat.filled    = filled_r;
    stat.count     = count_r;
  end

  // Next state of the bookkeeping
  always_comb begin
    count_nxt     = count_r;
    filled_nxt    = filled_r;
    cur_start_nxt = cur_start_r;
    last_col_nxt  = last_col_r;
    q_nxt         = q_r;
    p_nxt         = p_r;
    end_nxt       = end_r;
    j_nxt         = j_r;
    touched_nxt   = touched_r;
    pend_v_nxt    = pend_v_r;
    out_v_nxt     = out_v_r;
    rowcnt_nxt    = rowcnt_r;

    if (cmd.clear_b) begin
      count_nxt  = '0;
      filled_nxt = '0;
    end
    if (cmd.latch) begin
      j_nxt = '0;
    end
    if (cmd.fill_init) begin
      q_nxt = filled_r;
    end
    // open skipped rows one per cycle
    if (cmd.fill_wr) begin
      if (q_r == {1'b0, row_r}) begin
        filled_nxt    = row_p1;
        cur_start_nxt = count_r;
      end else begin
        q_nxt = q_r + 1'b1;
      end
    end
    if (cmd.wr_b) begin
      count_nxt    = count_r + 1'b1;
      last_col_nxt = col_r;
    end
    if (cmd.rs_rd1) begin
      p_nxt = ({1'b0, col_r} < filled_r) ? rs_rdata : count_r;
    end
    if (cmd.rs_rd2) begin
      end_nxt = (k_p1 < filled_r) ? rs_rdata : count_r;
    end
    if (cmd.acc_add) begin
      touched_nxt[srmm_pkg::ACC_AW'(b_col)] = 1'b1;
    end
    if (cmd.p_inc) begin
      p_nxt = p_r + 1'b1;
    end
    if (cmd.j_inc) begin
      j_nxt = j_r + 1'b1;
    end
    if (cmd.c_take) begin
      pend_v_nxt = 1'b1;
    end
    // drain the output register
    if (out.ready) begin
      out_v_nxt = 1'b0;
    end
    if (cmd.c_push) begin
      out_v_nxt = 1'b1;
    end
    if (cmd.c_fin) begin
      out_v_nxt   = 1'b1;
      pend_v_nxt  = 1'b0;
      touched_nxt = '0;
      rowcnt_nxt  = rowcnt_r + 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      filled_r  <= '0;
      touched_r <= '0;
      pend_v_r  <= 1'b0;
      out_v_r   <= 1'b0;
      rowcnt_r  <= '0;
      j_r       <= '0;
    end else begin
      count_r   <= count_nxt;
      filled_r  <= filled_nxt;
      touched_r <= touched_nxt;
      pend_v_r  <= pend_v_nxt;
      out_v_r   <= out_v_nxt;
      rowcnt_r  <= rowcnt_nxt;
      j_r       <= j_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cur_start_r <= cur_start_nxt;
    last_col_r  <= last_col_nxt;
    q_r         <= q_nxt;
    p_r         <= p_nxt;
    end_r       <= end_nxt;
    if (cmd.latch) begin
      row_r <= in_row;
      col_r <= in_col;
      val_r <= in_value;
    end
    // 32 x 32 signed product, sign-extended to the accumulator width
    if (cmd.mul) begin
      prod_r <= val_r * b_val;
    end
    if (cmd.c_take || cmd.c_push) begin
      pend_col_r <= IDX_W'(j_r);
      pend_val_r <= cand_val;
    end
    if (cmd.c_push) begin
      out_row_r   <= rowcnt_r;
      out_col_r   <= pend_col_r;
      out_val_r   <= pend_val_r;
      out_empty_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else if (cmd.c_fin) begin
      out_row_r   <= rowcnt_r;
      out_col_r   <= pend_v_r ? pend_col_r : '0;
      out_val_r   <= pend_v_r ? pend_val_r : '0;
      out_empty_r <= !pend_v_r;
      out_last_r  <= 1'b1;
    end
  end

  assign out.valid     = out_v_r;
  assign out.out_row   = out_row_r;
  assign out.out_col   = out_col_r;
  assign out.out_value = $signed(out_val_r);
  assign out.empty_row = out_empty_r;
  assign out.last      = out_last_r;

endmodule

>>> rtl/core/srmm_ctrl.sv
// ----------------------------------------------------------------------------
// srmm_ctrl
// Sequencer: loads and clears B, walks a B row per A element, scans columns on close.
// ----------------------------------------------------------------------------
module srmm_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [1:0]         in_op,
  output logic               in_ready,
  input  srmm_pkg::stat_t    stat,
  output srmm_pkg::cmd_t     cmd,
  output srmm_pkg::state_t   state
);

  srmm_pkg::state_t state_r, state_nxt;
  logic             in_fire;

  assign in_fire = in_valid && in_ready;
  assign state   = state_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      srmm_pkg::S_IDLE: begin
        if (in_fire) begin
          case (srmm_pkg::op_t'(in_op))
            srmm_pkg::OP_LOAD_B:  state_nxt = srmm_pkg::S_LD_CHK;
            srmm_pkg::OP_A_ELEM:  state_nxt = srmm_pkg::S_A_RD0;
            srmm_pkg::OP_CLOSE:   state_nxt = srmm_pkg::S_C_RD;
            default:              state_nxt = srmm_pkg::S_IDLE;
          endcase
        end
      end
      srmm_pkg::S_LD_CHK: begin
        if (!stat.ld_ok)        state_nxt = srmm_pkg::S_IDLE;
        else if (stat.ld_open)  state_nxt = srmm_pkg::S_LD_FILL;
        else                    state_nxt = srmm_pkg::S_LD_WR;
      end
      srmm_pkg::S_LD_FILL: begin
        if (stat.fill_last) state_nxt = srmm_pkg::S_LD_WR;
      end
      srmm_pkg::S_LD_WR: state_nxt = srmm_pkg::S_IDLE;
      srmm_pkg::S_A_RD0: begin
        state_nxt = stat.a_ok ? srmm_pkg::S_A_RD1 : srmm_pkg::S_IDLE;
      end
      srmm_pkg::S_A_RD1: state_nxt = srmm_pkg::S_A_RD2;
      srmm_pkg::S_A_RD2: state_nxt = srmm_pkg::S_A_BRD;
      srmm_pkg::S_A_BRD: begin
        state_nxt = stat.p_done ? srmm_pkg::S_IDLE : srmm_pkg::S_A_MUL;
      end
      srmm_pkg::S_A_MUL: begin
        state_nxt = stat.j_skip ? srmm_pkg::S_A_BRD : srmm_pkg::S_A_ADD;
      end
      srmm_pkg::S_A_ADD: state_nxt = srmm_pkg::S_A_BRD;
      srmm_pkg::S_C_RD: begin
        if (stat.c_done)       state_nxt = srmm_pkg::S_C_FIN;
        else if (stat.touched) state_nxt = srmm_pkg::S_C_EVAL;
      end
      srmm_pkg::S_C_EVAL: begin
        if (!stat.kept || !stat.pend_v || stat.out_free) state_nxt = srmm_pkg::S_C_RD;
      end
      srmm_pkg::S_C_FIN: begin
        if (stat.out_free) state_nxt = srmm_pkg::S_IDLE;
      end
      default: state_nxt = srmm_pkg::S_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      srmm_pkg::S_IDLE: begin
        in_ready    = 1'b1;
        cmd.latch   = in_fire;
        cmd.clear_b = in_fire && (srmm_pkg::op_t'(in_op) == srmm_pkg::OP_CLEAR_B);
      end
      srmm_pkg::S_LD_CHK:  cmd.fill_init = stat.ld_ok && stat.ld_open;
      srmm_pkg::S_LD_FILL: cmd.fill_wr   = 1'b1;
      srmm_pkg::S_LD_WR:   cmd.wr_b      = 1'b1;
      srmm_pkg::S_A_RD0:   cmd.rs_rd0    = stat.a_ok;
      srmm_pkg::S_A_RD1:   cmd.rs_rd1    = 1'b1;
      srmm_pkg::S_A_RD2:   cmd.rs_rd2    = 1'b1;
      srmm_pkg::S_A_BRD:   cmd.b_rd      = !stat.p_done;
      srmm_pkg::S_A_MUL: begin
        cmd.mul   = !stat.j_skip;
        cmd.p_inc = stat.j_skip;
      end
      srmm_pkg::S_A_ADD: begin
        cmd.acc_add = 1'b1;
        cmd.p_inc   = 1'b1;
      end
      srmm_pkg::S_C_RD: begin
        cmd.c_rd  = !stat.c_done && stat.touched;
        cmd.j_inc = !stat.c_done && !stat.touched;
      end
      srmm_pkg::S_C_EVAL: begin
        cmd.c_take = stat.kept && !stat.pend_v;
        cmd.c_push = stat.kept && stat.pend_v && stat.out_free;
        cmd.j_inc  = !stat.kept || !stat.pend_v || stat.out_free;
      end
      srmm_pkg::S_C_FIN: cmd.c_fin = stat.out_free;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= srmm_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> rtl/core/sparse_row_matrix_multiply.sv
// ----------------------------------------------------------------------------
// sparse_row_matrix_multiply
// Row-wise sparse product C = A x B on Q16.16 values with a compressed-row
// B store, 64-bit saturating accumulators and thresholded row emission.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake          | payload
//  in_ch    | sink      | valid / ready      | op, row, col, value
//  out_ch   | source    | valid / ready      | out_row, out_col, out_value, empty_row, last
//  cfg_*    | APB slave | psel/penable/pready| inner_dim, b_cols, drop_threshold
//
//  Load B: a check, a row-start write per row opened (the new row and any skipped
//  ones), then the B store write; a rejected element stops after the check.
//  A element: row-start reads for the row's start and end, then per B row entry a
//  B read, a multiply and an accumulate (no accumulate for an out-of-range column).
//  Close row: each column checked, each touched one evaluated, then the final entry;
//  a full output register stalls the column scan. Sync reset, no clearing pass.
// ----------------------------------------------------------------------------
module sparse_row_matrix_multiply (
  input  logic        clk,
  input  logic        rst_n,
  srmm_in_if.sink     in_ch,
  srmm_out_if.source  out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  srmm_pkg::cfg_t   cfg_r;
  srmm_pkg::cmd_t   cmd;
  srmm_pkg::stat_t  stat;
  srmm_pkg::state_t state;
  logic             cfg_wr;
  logic [srmm_pkg::REG_IDX_W-1:0] reg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign reg_idx    = cfg_paddr[3:2];

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.inner_dim      <= srmm_pkg::INNER_DIM_RST;
      cfg_r.b_cols         <= srmm_pkg::B_COLS_RST;
      cfg_r.drop_threshold <= srmm_pkg::DROP_THR_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        srmm_pkg::REG_INNER_DIM: cfg_r.inner_dim      <= cfg_pwdata[6:0];
        srmm_pkg::REG_B_COLS:    cfg_r.b_cols         <= cfg_pwdata[6:0];
        srmm_pkg::REG_DROP_THR:  cfg_r.drop_threshold <= cfg_pwdata[30:0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    case (reg_idx)
      srmm_pkg::REG_INNER_DIM: cfg_prdata = {25'd0, cfg_r.inner_dim};
      srmm_pkg::REG_B_COLS:    cfg_prdata = {25'd0, cfg_r.b_cols};
      srmm_pkg::REG_DROP_THR:  cfg_prdata = {1'b0, cfg_r.drop_threshold};
      default:                 cfg_prdata = '0;
    endcase
  end

  srmm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_op    (in_ch.op),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd),
    .state    (state)
  );

  srmm_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_row   (in_ch.row),
    .in_col   (in_ch.col),
    .in_value (in_ch.value),
    .cfg      (cfg_r),
    .cmd      (cmd),
    .stat     (stat),
    .out      (out_ch)
  );

`ifndef SYNTHESIS
  a_filled_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stat.filled <= srmm_pkg::DIM_W'(srmm_pkg::MAX_DIM))
    else $error("row fill count beyond dimension");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stat.count <= srmm_pkg::CNT_W'(srmm_pkg::MAX_NNZ))
    else $error("B entry count beyond store depth");

  a_empty_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.empty_row |-> out_ch.last && out_ch.out_value == 0)
    else $error("empty-row marker malformed");

  a_close_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.c_fin |=> out_ch.valid && out_ch.last && state == srmm_pkg::S_IDLE)
    else $error("row close did not present final entry");
`endif

endmodule
